// ----- src/mlfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types, codes and sizes for the motion light fade controller.
// ----------------------------------------------------------------------------
package mlfc_pkg;

  localparam int TICKS_PER_SECOND = 20;

  localparam int LVL_W      = 8;
  localparam int SEC_W      = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int OP_W       = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Fade tick counters hold up to 255 seconds worth of ticks.
  localparam int FTICK_W = $clog2(((1 << SEC_W) - 1) * TICKS_PER_SECOND + 1);
  // Inactivity counter, saturating at all ones.
  localparam int ITICK_W = 21;

  // Serial fade arithmetic: start*(T-e) + target*e, then (2*that + T) / (2*T).
  localparam int ACC_W = LVL_W + FTICK_W;
  localparam int NUM_W = ACC_W + 1;
  localparam int DSH_W = FTICK_W + 1 + (LVL_W - 1);
  localparam int CNT_W = $clog2(FTICK_W);

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd300;
  localparam logic [LVL_W-1:0]     LUX_THR_RST   = 8'd50;
  localparam logic [SEC_W-1:0]     FADE_IN_RST   = 8'd2;
  localparam logic [SEC_W-1:0]     FADE_OUT_RST  = 8'd5;
  localparam logic [LVL_W-1:0]     AMB_LUX_RST   = 8'd100;
  localparam logic [LVL_W-1:0]     SCENE_RST     = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_TICK         = 4'd0,
    OP_LUX          = 4'd1,
    OP_MOTION_START = 4'd2,
    OP_MOTION_END   = 4'd3,
    OP_SCENE        = 4'd4,
    OP_FORCE_ON     = 4'd5,
    OP_FORCE_OFF    = 4'd6,
    OP_ENABLE       = 4'd7,
    OP_DISABLE      = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    M_IDLE     = 2'd0,
    M_FADE_IN  = 2'd1,
    M_ON       = 2'd2,
    M_FADE_OUT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    K_DIM = 2'd0,
    K_ON  = 2'd1,
    K_OFF = 2'd2
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_LUX_THR  = 2'd1,
    CFG_FADE_IN  = 2'd2,
    CFG_FADE_OUT = 2'd3
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_WAIT = 7'b0000001,
    ST_EXEC = 7'b0000010,
    ST_FADE = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_POST = 7'b1000000
  } state_t;

  function automatic logic [FTICK_W-1:0] fade_ticks(input logic [SEC_W-1:0] secs);
    logic [FTICK_W-1:0] wide;
    wide = FTICK_W'(secs);
    return wide * FTICK_W'(TICKS_PER_SECOND);
  endfunction

endpackage

// ----- src/motion_light_fade_controller_top.sv -----
// ----------------------------------------------------------------------------
// motion_light_fade_controller_top
// Motion-activated lamp controller with timed fades and inactivity timeout.
// ----------------------------------------------------------------------------
// One event beat is taken at a time and gives zero, one or two result beats.
// A tick that leaves the fade alone passes through EXEC, FADE and POST, one
// that ends a fade through EXEC, FADE, FIN and POST, and one that advances a
// running fade short of its end also through MUL and DIV before FIN; all other
// beats pass through EXEC and POST. Then the next event beat can be taken. The
// fade level is formed by a 13-step shift-and-add multiplier followed by an
// 8-step restoring divider, one bit per cycle each. Work on a beat starts only
// once the results of the previous one have all been taken, so output stalls
// delay it; meanwhile the next event beat is already accepted and held.
module motion_light_fade_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: lux_value[7:0], new_master[15:8]
  input  logic [15:0]                       in_tdata,
  // tuser: operation[3:0]
  input  logic [mlfc_pkg::OP_W-1:0]         in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: level[7:0], lamp_mode[9:8], zero fill [15:10]
  output logic [15:0]                       out_tdata,
  // tuser: event_kind[1:0]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [mlfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mlfc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mlfc_pkg::*;

  // configuration
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [LVL_W-1:0]     lux_thr_r;
  logic [SEC_W-1:0]     fade_in_s_r, fade_out_s_r;

  // lamp state
  logic               enabled_r, enabled_nxt;
  mode_t              mode_r, mode_nxt;
  logic [LVL_W-1:0]   amb_lux_r, amb_lux_nxt;
  logic [LVL_W-1:0]   scene_r, scene_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [LVL_W-1:0]   fstart_r, fstart_nxt;
  logic [LVL_W-1:0]   ftarget_r, ftarget_nxt;
  logic [FTICK_W-1:0] felapsed_r, felapsed_nxt;
  logic [FTICK_W-1:0] ftotal_r, ftotal_nxt;
  logic               frun_r, frun_nxt;
  logic [ITICK_W-1:0] idle_ticks_r, idle_ticks_nxt;
  logic               idle_run_r, idle_run_nxt;

  // sequencer
  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [LVL_W-1:0]   lux_in_r, lux_in_nxt;
  logic [LVL_W-1:0]   nm_in_r, nm_in_nxt;
  logic               fade_was_r, fade_was_nxt;
  logic               fdone_r, fdone_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // serial multiplier and divider
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-1:0]   ma_r, ma_nxt, mb_r, mb_nxt;
  logic [FTICK_W-1:0] xa_r, xa_nxt, xb_r, xb_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [DSH_W-1:0]   dsh_r, dsh_nxt;
  logic [LVL_W-1:0]   quo_r, quo_nxt;

  // results of the beat in progress
  logic [1:0]         pend_cnt_r, pend_cnt_nxt;
  kind_t              pend_kind_r [2];
  kind_t              pend_kind_nxt [2];
  logic [LVL_W-1:0]   pend_lvl_r [2];
  logic [LVL_W-1:0]   pend_lvl_nxt [2];

  // output buffer
  logic [1:0]         obuf_cnt_r, obuf_cnt_nxt;
  kind_t              obuf_kind_r [2];
  kind_t              obuf_kind_nxt [2];
  logic [LVL_W-1:0]   obuf_lvl_r [2];
  logic [LVL_W-1:0]   obuf_lvl_nxt [2];
  mode_t              obuf_mode_r [2];
  mode_t              obuf_mode_nxt [2];
  logic               obuf_last_r [2];
  logic               obuf_last_nxt [2];

  logic [ITICK_W-1:0] idle_limit;
  logic               in_beat;
  logic               out_beat;

  assign idle_limit = ITICK_W'(timeout_r) * ITICK_W'(TICKS_PER_SECOND);
  assign in_tready  = (state_r == ST_WAIT);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = (obuf_cnt_r != 2'd0);
  assign out_beat   = out_tvalid && out_tready;
  assign out_tdata  = {6'd0, obuf_mode_r[0], obuf_lvl_r[0]};
  assign out_tuser  = obuf_kind_r[0];
  assign out_tlast  = obuf_last_r[0];

  // --------------------------------------------------------------------------
  // Event processing
  // --------------------------------------------------------------------------
  always_comb begin
    logic [FTICK_W-1:0] e_new;
    logic [ITICK_W-1:0] it_inc;
    logic [ACC_W-1:0]   acc_sum;
    logic               do_fin, fin_prep, do_fout;
    logic [1:0]         em_n;
    kind_t              em_kind [2];
    logic [LVL_W-1:0]   em_lvl [2];
    logic [2:0]         cnt_sum;
    logic [1:0]         slot;

    enabled_nxt    = enabled_r;
    mode_nxt       = mode_r;
    amb_lux_nxt    = amb_lux_r;
    scene_nxt      = scene_r;
    level_nxt      = level_r;
    fstart_nxt     = fstart_r;
    ftarget_nxt    = ftarget_r;
    felapsed_nxt   = felapsed_r;
    ftotal_nxt     = ftotal_r;
    frun_nxt       = frun_r;
    idle_ticks_nxt = idle_ticks_r;
    idle_run_nxt   = idle_run_r;
    state_nxt      = state_r;
    op_nxt         = op_r;
    lux_in_nxt     = lux_in_r;
    nm_in_nxt      = nm_in_r;
    fade_was_nxt   = fade_was_r;
    fdone_nxt      = fdone_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    ma_nxt         = ma_r;
    mb_nxt         = mb_r;
    xa_nxt         = xa_r;
    xb_nxt         = xb_r;
    rem_nxt        = rem_r;
    dsh_nxt        = dsh_r;
    quo_nxt        = quo_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_kind_nxt  = pend_kind_r;
    pend_lvl_nxt   = pend_lvl_r;

    e_new    = felapsed_r;
    it_inc   = idle_ticks_r;
    acc_sum  = acc_r + (xa_r[0] ? ma_r : '0) + (xb_r[0] ? mb_r : '0);
    do_fin   = 1'b0;
    fin_prep = 1'b0;
    do_fout  = 1'b0;
    em_n     = 2'd0;
    em_kind  = '{K_DIM, K_DIM};
    em_lvl   = '{'0, '0};
    cnt_sum  = '0;
    slot     = '0;

    unique case (state_r)
      ST_WAIT: begin
        if (in_beat) begin
          op_nxt       = in_tuser;
          lux_in_nxt   = in_tdata[7:0];
          nm_in_nxt    = in_tdata[15:8];
          pend_cnt_nxt = 2'd0;
          state_nxt    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // hold until the previous beat's results are gone
        if (obuf_cnt_r == 2'd0) begin
          state_nxt = ST_POST;
          unique case (op_r)
            OP_TICK: begin
              // inactivity counter first, fade afterwards
              fade_was_nxt = frun_r;
              state_nxt    = ST_FADE;
              if (idle_run_r) begin
                it_inc         = (idle_ticks_r != '1) ? idle_ticks_r + 1'b1 : idle_ticks_r;
                idle_ticks_nxt = it_inc;
                if (it_inc >= idle_limit) begin
                  idle_run_nxt = 1'b0;
                  do_fout      = (mode_r == M_ON);
                end
              end
            end
            OP_LUX: begin
              if (enabled_r) amb_lux_nxt = lux_in_r;
            end
            OP_MOTION_START: begin
              if (enabled_r) begin
                unique case (mode_r)
                  M_IDLE: begin
                    if (amb_lux_r < lux_thr_r) begin
                      level_nxt = '0;
                      do_fin    = 1'b1;
                      fin_prep  = 1'b1;
                    end
                  end
                  M_FADE_OUT: begin
                    frun_nxt = 1'b0;
                    do_fin   = 1'b1;
                  end
                  M_ON: begin
                    idle_ticks_nxt = '0;
                    idle_run_nxt   = 1'b1;
                  end
                  M_FADE_IN: ;
                endcase
              end
            end
            OP_SCENE: begin
              scene_nxt = nm_in_r;
              if (mode_r == M_FADE_IN) begin
                ftarget_nxt = nm_in_r;
              end else if (mode_r == M_FADE_OUT && nm_in_r != '0) begin
                frun_nxt       = 1'b0;
                mode_nxt       = M_ON;
                level_nxt      = nm_in_r;
                idle_ticks_nxt = '0;
                idle_run_nxt   = 1'b1;
              end
            end
            OP_FORCE_ON: begin
              if (enabled_r && mode_r == M_IDLE) begin
                level_nxt = '0;
                do_fin    = 1'b1;
                fin_prep  = 1'b1;
              end
            end
            OP_FORCE_OFF: begin
              if (enabled_r && (mode_r == M_ON || mode_r == M_FADE_IN)) begin
                idle_run_nxt = 1'b0;
                frun_nxt     = 1'b0;
                do_fout      = 1'b1;
              end
            end
            OP_ENABLE, OP_DISABLE: begin
              enabled_nxt  = (op_r == OP_ENABLE);
              mode_nxt     = M_IDLE;
              level_nxt    = '0;
              idle_run_nxt = 1'b0;
              frun_nxt     = 1'b0;
            end
            default: ;
          endcase

          if (do_fin) begin
            if (fade_in_s_r == '0) begin
              level_nxt      = scene_r;
              mode_nxt       = M_ON;
              em_n           = 2'd1;
              em_kind[0]     = K_ON;
              em_lvl[0]      = scene_r;
              idle_ticks_nxt = '0;
              idle_run_nxt   = 1'b1;
            end else begin
              if (fin_prep) begin
                em_n       = 2'd1;
                em_kind[0] = K_ON;
                em_lvl[0]  = level_nxt;
              end
              fstart_nxt   = level_nxt;
              ftarget_nxt  = scene_r;
              ftotal_nxt   = fade_ticks(fade_in_s_r);
              felapsed_nxt = '0;
              frun_nxt     = 1'b1;
              mode_nxt     = M_FADE_IN;
            end
          end

          if (do_fout) begin
            if (fade_out_s_r == '0) begin
              level_nxt  = '0;
              mode_nxt   = M_IDLE;
              em_n       = 2'd1;
              em_kind[0] = K_OFF;
              em_lvl[0]  = '0;
            end else begin
              fstart_nxt   = scene_r;
              level_nxt    = scene_r;
              ftarget_nxt  = '0;
              ftotal_nxt   = fade_ticks(fade_out_s_r);
              felapsed_nxt = '0;
              frun_nxt     = 1'b1;
              mode_nxt     = M_FADE_OUT;
            end
          end
        end
      end

      ST_FADE: begin
        state_nxt = ST_POST;
        if (fade_was_r && frun_r) begin
          e_new        = (felapsed_r < ftotal_r) ? felapsed_r + 1'b1 : felapsed_r;
          felapsed_nxt = e_new;
          if (ftotal_r == '0 || e_new >= ftotal_r) begin
            fdone_nxt = 1'b1;
            quo_nxt   = ftarget_r;
            state_nxt = ST_FIN;
          end else begin
            fdone_nxt = 1'b0;
            acc_nxt   = '0;
            ma_nxt    = ACC_W'(fstart_r);
            mb_nxt    = ACC_W'(ftarget_r);
            xa_nxt    = ftotal_r - e_new;
            xb_nxt    = e_new;
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        // one multiplier bit of each product per cycle
        acc_nxt = acc_sum;
        ma_nxt  = {ma_r[ACC_W-2:0], 1'b0};
        mb_nxt  = {mb_r[ACC_W-2:0], 1'b0};
        xa_nxt  = {1'b0, xa_r[FTICK_W-1:1]};
        xb_nxt  = {1'b0, xb_r[FTICK_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FTICK_W - 1)) begin
          // rounding half up: (2*sum + T) / (2*T)
          rem_nxt   = NUM_W'({acc_sum, 1'b0}) + NUM_W'(ftotal_r);
          dsh_nxt   = {ftotal_r, 1'b0, {(LVL_W-1){1'b0}}};
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        // one quotient bit per cycle, most significant first
        if (rem_r >= NUM_W'(dsh_r)) begin
          rem_nxt = rem_r - NUM_W'(dsh_r);
          quo_nxt = {quo_r[LVL_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[LVL_W-2:0], 1'b0};
        end
        dsh_nxt = {1'b0, dsh_r[DSH_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LVL_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        level_nxt  = quo_r;
        em_n       = 2'd1;
        em_kind[0] = K_DIM;
        em_lvl[0]  = quo_r;
        if (fdone_r) begin
          frun_nxt = 1'b0;
          if (mode_r == M_FADE_OUT) begin
            mode_nxt   = M_IDLE;
            em_n       = 2'd2;
            em_kind[1] = K_OFF;
            em_lvl[1]  = '0;
          end else if (mode_r == M_FADE_IN) begin
            mode_nxt       = M_ON;
            em_n           = 2'd2;
            em_kind[1]     = K_ON;
            em_lvl[1]      = scene_r;
            idle_ticks_nxt = '0;
            idle_run_nxt   = 1'b1;
          end
        end
        state_nxt = ST_POST;
      end

      ST_POST: begin
        state_nxt = ST_WAIT;
      end

      default: state_nxt = ST_WAIT;
    endcase

    // append this cycle's results, dropping any beyond two
    if (em_n != 2'd0) begin
      for (int j = 0; j < 2; j++) begin
        if (2'(j) < em_n) begin
          slot = pend_cnt_r + 2'(j);
          if (slot < 2'd2) begin
            pend_kind_nxt[slot[0]] = em_kind[j];
            pend_lvl_nxt[slot[0]]  = em_lvl[j];
          end
        end
      end
      cnt_sum      = 3'(pend_cnt_r) + 3'(em_n);
      pend_cnt_nxt = (cnt_sum > 3'd2) ? 2'd2 : cnt_sum[1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer
  // --------------------------------------------------------------------------
  always_comb begin
    obuf_cnt_nxt  = obuf_cnt_r;
    obuf_kind_nxt = obuf_kind_r;
    obuf_lvl_nxt  = obuf_lvl_r;
    obuf_mode_nxt = obuf_mode_r;
    obuf_last_nxt = obuf_last_r;
    if (state_r == ST_POST) begin
      // buffer is empty here: processing only starts once it drained
      obuf_cnt_nxt = pend_cnt_r;
      for (int i = 0; i < 2; i++) begin
        obuf_kind_nxt[i] = pend_kind_r[i];
        obuf_lvl_nxt[i]  = pend_lvl_r[i];
        obuf_mode_nxt[i] = mode_r;
        obuf_last_nxt[i] = (2'(i + 1) == pend_cnt_r);
      end
    end else if (out_beat) begin
      obuf_cnt_nxt     = obuf_cnt_r - 1'b1;
      obuf_kind_nxt[0] = obuf_kind_r[1];
      obuf_lvl_nxt[0]  = obuf_lvl_r[1];
      obuf_mode_nxt[0] = obuf_mode_r[1];
      obuf_last_nxt[0] = obuf_last_r[1];
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RST;
      lux_thr_r    <= LUX_THR_RST;
      fade_in_s_r  <= FADE_IN_RST;
      fade_out_s_r <= FADE_OUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TIMEOUT:  timeout_r    <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_LUX_THR:  lux_thr_r    <= cfg_wdata[LVL_W-1:0];
        CFG_FADE_IN:  fade_in_s_r  <= cfg_wdata[SEC_W-1:0];
        CFG_FADE_OUT: fade_out_s_r <= cfg_wdata[SEC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      mode_r       <= M_IDLE;
      amb_lux_r    <= AMB_LUX_RST;
      scene_r      <= SCENE_RST;
      level_r      <= '0;
      fstart_r     <= '0;
      ftarget_r    <= '0;
      felapsed_r   <= '0;
      ftotal_r     <= '0;
      frun_r       <= 1'b0;
      idle_ticks_r <= '0;
      idle_run_r   <= 1'b0;
      state_r      <= ST_WAIT;
      fade_was_r   <= 1'b0;
      fdone_r      <= 1'b0;
      cnt_r        <= '0;
      pend_cnt_r   <= '0;
      obuf_cnt_r   <= '0;
    end else begin
      enabled_r    <= enabled_nxt;
      mode_r       <= mode_nxt;
      amb_lux_r    <= amb_lux_nxt;
      scene_r      <= scene_nxt;
      level_r      <= level_nxt;
      fstart_r     <= fstart_nxt;
      ftarget_r    <= ftarget_nxt;
      felapsed_r   <= felapsed_nxt;
      ftotal_r     <= ftotal_nxt;
      frun_r       <= frun_nxt;
      idle_ticks_r <= idle_ticks_nxt;
      idle_run_r   <= idle_run_nxt;
      state_r      <= state_nxt;
      fade_was_r   <= fade_was_nxt;
      fdone_r      <= fdone_nxt;
      cnt_r        <= cnt_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      obuf_cnt_r   <= obuf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    lux_in_r    <= lux_in_nxt;
    nm_in_r     <= nm_in_nxt;
    acc_r       <= acc_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    xa_r        <= xa_nxt;
    xb_r        <= xb_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    quo_r       <= quo_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_lvl_r  <= pend_lvl_nxt;
    obuf_kind_r <= obuf_kind_nxt;
    obuf_lvl_r  <= obuf_lvl_nxt;
    obuf_mode_r <= obuf_mode_nxt;
    obuf_last_r <= obuf_last_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fade_needs_fade_mode: assert property (@(posedge clk) disable iff (!rst_n)
    frun_r |-> (mode_r == M_FADE_IN || mode_r == M_FADE_OUT))
    else $error("fade counter running outside a fade mode");

  a_exec_waits_for_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && obuf_cnt_r != 2'd0) |=> (state_r == ST_EXEC))
    else $error("event processed while earlier results still pending");

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {dsh_r, 1'b0}))
    else $error("fade quotient overflows the level width");

  a_obuf_order: assert property (@(posedge clk) disable iff (!rst_n)
    (obuf_cnt_r == 2'd2) |-> (!obuf_last_r[0] && obuf_last_r[1]))
    else $error("output buffer last flags out of order");

  a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (obuf_cnt_r != 2'd3) && (pend_cnt_r != 2'd3))
    else $error("result count beyond two");

endmodule

// ----- sim/mlfc_lamp_checker.sv -----
// ----------------------------------------------------------------------------
// mlfc_lamp_checker
// Watches the event, result and register ports of the lamp controller. It
// keeps its own copy of the lamp state, predicts the result beats of every
// accepted event beat and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mlfc_lamp_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: lux_value[7:0], new_master[15:8]
  input  logic [15:0]                       in_tdata,
  // tuser: operation[3:0]
  input  logic [mlfc_pkg::OP_W-1:0]         in_tuser,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  // tdata: level[7:0], lamp_mode[9:8], zero fill [15:10]
  input  logic [15:0]                       out_tdata,
  // tuser: event_kind[1:0]
  input  logic [1:0]                        out_tuser,
  input  logic                              out_tlast,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [mlfc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mlfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                errors,
  output int                                pending,
  output int                                events_taken,
  output int                                notes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import mlfc_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] level;
    mode_t      mode;
    logic       last;
  } note_t;

  note_t lamp_notes_q[$];

  // register copies
  logic [15:0] tmo_secs;
  logic [7:0]  lux_thr, fin_s, fout_s;

  // lamp state copy
  logic               on_en;
  mode_t              lamp;
  logic [7:0]         amb, master, lvl, f_from, f_to;
  logic [FTICK_W-1:0] f_done, f_len;
  logic               f_run;
  logic [20:0]        quiet;
  logic               quiet_run;

  // results of the step in progress
  kind_t      note_kind [2];
  logic [7:0] note_lvl  [2];
  int         n_notes;

  initial begin
    errors = 0;
    pending = 0;
    events_taken = 0;
    notes_checked = 0;
  end

  task automatic reset_lamp();
    tmo_secs  = TIMEOUT_RST;
    lux_thr   = LUX_THR_RST;
    fin_s     = FADE_IN_RST;
    fout_s    = FADE_OUT_RST;
    on_en     = 1'b0;
    lamp      = M_IDLE;
    amb       = AMB_LUX_RST;
    master    = SCENE_RST;
    lvl       = '0;
    f_from    = '0;
    f_to      = '0;
    f_done    = '0;
    f_len     = '0;
    f_run     = 1'b0;
    quiet     = '0;
    quiet_run = 1'b0;
    lamp_notes_q.delete();
  endtask

  task automatic note(kind_t k, logic [7:0] v);
    if (n_notes < 2) begin
      note_kind[n_notes] = k;
      note_lvl[n_notes] = v;
      n_notes++;
    end
  endtask

  task automatic quiet_restart();
    quiet = '0;
    quiet_run = 1'b1;
  endtask

  task automatic launch_fade_in(logic prep);
    if (fin_s == 0) begin
      lvl = master;
      lamp = M_ON;
      note(K_ON, master);
      quiet_restart();
    end else begin
      // fading in from idle announces the lamp first, still dark
      if (prep) note(K_ON, lvl);
      f_from = lvl;
      f_to   = master;
      f_len  = FTICK_W'(fin_s) * FTICK_W'(TICKS_PER_SECOND);
      f_done = '0;
      f_run  = 1'b1;
      lamp   = M_FADE_IN;
    end
  endtask

  task automatic launch_fade_out();
    if (fout_s == 0) begin
      lvl = '0;
      lamp = M_IDLE;
      note(K_OFF, 8'd0);
    end else begin
      f_from = master;
      lvl    = master;
      f_to   = '0;
      f_len  = FTICK_W'(fout_s) * FTICK_W'(TICKS_PER_SECOND);
      f_done = '0;
      f_run  = 1'b1;
      lamp   = M_FADE_OUT;
    end
  endtask

  task automatic fade_step();
    longint     s, d, t, num;
    logic [7:0] m;
    logic       done;
    if (f_done < f_len) f_done++;
    if (f_len == 0 || f_done >= f_len) begin
      m = f_to;
      done = 1'b1;
    end else begin
      // start + (target - start) * e / T, rounded half up
      s = longint'(f_from);
      d = longint'(f_to) - s;
      t = longint'(f_len);
      num = 2 * s * t + 2 * d * longint'(f_done) + t;
      m = 8'(num / (2 * t));
      done = 1'b0;
    end
    lvl = m;
    note(K_DIM, lvl);
    if (done) begin
      f_run = 1'b0;
      if (lamp == M_FADE_OUT) begin
        lamp = M_IDLE;
        note(K_OFF, 8'd0);
      end else if (lamp == M_FADE_IN) begin
        lamp = M_ON;
        note(K_ON, master);
        quiet_restart();
      end
    end
  endtask

  task automatic quiet_step();
    int unsigned lim;
    lim = 32'(tmo_secs) * 32'(TICKS_PER_SECOND);
    if (quiet != 21'h1FFFFF) quiet++;
    if (quiet >= lim) begin
      quiet_run = 1'b0;
      if (lamp == M_ON) launch_fade_out();
    end
  endtask

  task automatic step_lamp(logic [3:0] op, logic [7:0] lux, logic [7:0] nm);
    logic was_fading;
    n_notes = 0;
    case (op)
      OP_TICK: begin
        // inactivity first; a fade begun by this tick waits for the next one
        was_fading = f_run;
        if (quiet_run) quiet_step();
        if (was_fading && f_run) fade_step();
      end
      OP_LUX: if (on_en) amb = lux;
      OP_MOTION_START: begin
        if (on_en) begin
          if (lamp == M_IDLE) begin
            if (amb < lux_thr) begin
              lvl = '0;
              launch_fade_in(1'b1);
            end
          end else if (lamp == M_FADE_OUT) begin
            f_run = 1'b0;
            launch_fade_in(1'b0);
          end else if (lamp == M_ON) begin
            quiet_restart();
          end
        end
      end
      OP_SCENE: begin
        master = nm;
        if (lamp == M_FADE_IN) begin
          f_to = nm;
        end else if (lamp == M_FADE_OUT && nm != 0) begin
          f_run = 1'b0;
          lamp = M_ON;
          lvl = nm;
          quiet_restart();
        end
      end
      OP_FORCE_ON: begin
        if (on_en && lamp == M_IDLE) begin
          lvl = '0;
          launch_fade_in(1'b1);
        end
      end
      OP_FORCE_OFF: begin
        if (on_en && (lamp == M_ON || lamp == M_FADE_IN)) begin
          quiet_run = 1'b0;
          f_run = 1'b0;
          launch_fade_out();
        end
      end
      OP_ENABLE, OP_DISABLE: begin
        on_en = (op == OP_ENABLE);
        lamp = M_IDLE;
        lvl = '0;
        quiet_run = 1'b0;
        f_run = 1'b0;
      end
      default: ;
    endcase
    for (int k = 0; k < n_notes; k++)
      lamp_notes_q.push_back('{note_kind[k], note_lvl[k], lamp, (k == n_notes - 1)});
  endtask

  always @(posedge clk) begin
    note_t want;
    if (!rst_n) begin
      reset_lamp();
    end else begin
      if (out_tvalid && out_tready) begin
        notes_checked++;
        if (lamp_notes_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: kind %0d tdata %h last %b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          want = lamp_notes_q.pop_front();
          if (out_tuser !== want.kind || out_tdata !== {6'b0, want.mode, want.level} ||
              out_tlast !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected kind %0d level %0d mode %0d last %b",
                     $time, want.kind, want.level, want.mode, want.last);
            $display("%0t:   got kind %0d level %0d mode %0d last %b (tdata %h)",
                     $time, out_tuser, out_tdata[7:0], out_tdata[9:8], out_tlast,
                     out_tdata);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TIMEOUT:  tmo_secs = cfg_wdata;
          CFG_LUX_THR:  lux_thr  = cfg_wdata[7:0];
          CFG_FADE_IN:  fin_s    = cfg_wdata[7:0];
          CFG_FADE_OUT: fout_s   = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        events_taken++;
        step_lamp(in_tuser, in_tdata[7:0], in_tdata[15:8]);
      end
    end
    pending = lamp_notes_q.size();
  end

endmodule

// ----- sim/motion_light_fade_controller_top_tb.sv -----
// ----------------------------------------------------------------------------
// motion_light_fade_controller_top_tb
// Drives event beats and register writes into the lamp controller under
// random gaps and output stalls; a checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module motion_light_fade_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [15:0]           in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors, pending, events_taken, notes_checked;
  int cycles = 0;
  int settings_done = 0;
  int stall_left = 0;
  logic gaps_on = 1'b0;
  logic stalls_on = 1'b0;

  motion_light_fade_controller_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  mlfc_lamp_checker watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending),
    .events_taken  (events_taken),
    .notes_checked (notes_checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls: mostly short, now and then long
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_event(logic [3:0] op, logic [7:0] lux, logic [7:0] nm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = op;
    in_tdata = {nm, lux};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // drain, let a silent beat finish, then rewrite every register
  task automatic apply_settings(logic [15:0] to, logic [7:0] thr, logic [7:0] fin,
                                logic [7:0] fout);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = CFG_TIMEOUT;  cfg_wdata = to;   @(negedge clk);
    cfg_addr = CFG_LUX_THR;  cfg_wdata = thr;  @(negedge clk);
    cfg_addr = CFG_FADE_IN;  cfg_wdata = fin;  @(negedge clk);
    cfg_addr = CFG_FADE_OUT; cfg_wdata = fout; @(negedge clk);
    cfg_we = 1'b0;
    settings_done++;
  endtask

  function automatic logic [3:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return OP_TICK;
    if (r < 60) return OP_LUX;
    if (r < 70) return OP_MOTION_START;
    if (r < 73) return OP_MOTION_END;
    if (r < 79) return OP_SCENE;
    if (r < 85) return OP_FORCE_ON;
    if (r < 89) return OP_FORCE_OFF;
    if (r < 93) return OP_ENABLE;
    if (r < 95) return OP_DISABLE;
    return 4'($urandom_range(9, 15));
  endfunction

  initial begin
    logic [15:0] to;
    logic [7:0]  thr, fin, fout, lux, nm;
    int          n_items;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: slow fade in, instant fade out
    apply_settings(16'd0, 8'd255, 8'd1, 8'd0);
    send_event(4'd15, 8'hFF, 8'hFF);
    send_event(4'd9, 8'h00, 8'h00);
    send_event(OP_TICK, 8'h00, 8'h00);
    send_event(OP_LUX, 8'h00, 8'h00);
    send_event(OP_FORCE_ON, 8'h00, 8'h00);
    send_event(OP_SCENE, 8'h00, 8'hFF);
    send_event(OP_ENABLE, 8'h00, 8'h00);
    send_event(OP_LUX, 8'hFF, 8'h00);
    send_event(OP_MOTION_START, 8'h00, 8'h00);
    send_event(OP_LUX, 8'h00, 8'h00);
    send_event(OP_MOTION_START, 8'h00, 8'h00);
    send_event(OP_SCENE, 8'h00, 8'h80);
    send_event(OP_TICK, 8'h00, 8'h00);
    send_event(OP_MOTION_END, 8'h00, 8'h00);
    send_event(OP_FORCE_OFF, 8'h00, 8'h00);
    send_event(OP_FORCE_ON, 8'h00, 8'h00);
    send_event(OP_ENABLE, 8'h00, 8'h00);
    send_event(OP_DISABLE, 8'h00, 8'h00);

    // directed: instant on, zero timeout, slow fade out
    apply_settings(16'd0, 8'd255, 8'd0, 8'd1);
    send_event(OP_ENABLE, 8'h00, 8'h00);
    send_event(OP_SCENE, 8'h00, 8'hFF);
    send_event(OP_FORCE_ON, 8'h00, 8'h00);
    send_event(OP_TICK, 8'h00, 8'h00);
    send_event(OP_TICK, 8'h00, 8'h00);
    send_event(OP_SCENE, 8'h00, 8'hC8);
    send_event(OP_TICK, 8'h00, 8'h00);
    send_event(OP_MOTION_START, 8'h00, 8'h00);

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin to = 16'd0;     thr = 8'd255; fin = 8'd1;   fout = 8'd1;   end
        1: begin to = 16'd1;     thr = 8'd0;   fin = 8'd0;   fout = 8'd0;   end
        2: begin to = 16'd2;     thr = 8'd128; fin = 8'd2;   fout = 8'd1;   end
        3: begin to = 16'd65535; thr = 8'd255; fin = 8'd255; fout = 8'd255; end
        4: begin to = 16'd1;     thr = 8'd200; fin = 8'd1;   fout = 8'd2;   end
        5: begin to = 16'd0;     thr = 8'd255; fin = 8'd0;   fout = 8'd1;   end
        default: begin
          to   = 16'($urandom_range(0, 3));
          thr  = 8'($urandom_range(0, 255));
          fin  = 8'($urandom_range(0, 2));
          fout = 8'($urandom_range(0, 2));
        end
      endcase
      apply_settings(to, thr, fin, fout);
      gaps_on = (ph % 3 != 1);
      stalls_on = (ph % 4 != 2);
      n_items = (ph == 3) ? 60 : 130;
      send_event(OP_ENABLE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      for (int i = 1; i < n_items; i++) begin
        lux = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 60)) : 8'($urandom_range(0, 255));
        nm = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        send_event(pick_op(), lux, nm);
      end
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d event beats under %0d register settings, with directed corners",
             events_taken, settings_done);
    $display("and random gaps and stalls; %0d result beats were checked.", notes_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
